>>> rtl/core/mrsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsi_pkg
// Shared types, register indexes and saturation helper for the moving
// ray-sphere intersect pipeline.
// ----------------------------------------------------------------------------
package mrsi_pkg;

    typedef enum logic [2:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_CENTER_Z   = 3'd2,
        REG_RADIUS     = 3'd3,
        REG_VELOCITY_X = 3'd4,
        REG_VELOCITY_Y = 3'd5,
        REG_VELOCITY_Z = 3'd6,
        REG_OBJECT_ID  = 3'd7
    } reg_index_t;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam int          IN_W         = 168;
    localparam int          OUT_W        = 200;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][31:0] v;
        logic [30:0]      radius;
        logic [15:0]      object_id;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] o;
        logic [2:0][17:0] d;
        logic [2:0][31:0] mc;
        logic [31:0]      t;
        logic             miss;
    } ray_mid_t;

    typedef struct packed {
        logic             hit;
        logic [30:0]      distance;
        logic [2:0][31:0] p;
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
    } surf_t;

    typedef struct packed {
        logic             hit;
        logic [30:0]      distance;
        logic [2:0][31:0] p;
        logic [2:0]       neg;
    } hitpt_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (x < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/mrsi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsi_front
// Ten-stage front end: moved centre, offset, projection, discriminant.
// ----------------------------------------------------------------------------
module mrsi_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  wire                  in_valid,
    input  wire [2:0][31:0]      in_o,
    input  wire [2:0][17:0]      in_d,
    input  wire [16:0]           in_tm,
    input  mrsi_pkg::cfg_t       cfg,
    output logic                 out_valid,
    output logic [63:0]          out_rad,
    output mrsi_pkg::ray_mid_t   out_mid
);
    import mrsi_pkg::*;

    logic [9:0]          vld_reg;
    logic [2:0][31:0]    o_reg [10];
    logic [2:0][17:0]    d_reg [10];
    logic [16:0]         tm_reg;
    logic signed [49:0]  tv_reg [3];
    logic signed [49:0]  tv_next [3];
    logic [2:0][31:0]    mc_reg [2:9];
    logic [2:0][31:0]    mc_next;
    logic signed [31:0]  l_reg [3];
    logic signed [31:0]  l_next [3];
    logic signed [49:0]  dp_reg [3];
    logic signed [49:0]  dp_next [3];
    logic [63:0]         lsq_reg [3];
    logic [63:0]         lsq_next [3];
    logic signed [51:0]  dot_reg;
    logic signed [51:0]  dot_next;
    logic [63:0]         a_reg [5:8];
    logic [63:0]         a_next;
    logic signed [31:0]  t_reg [6:9];
    logic signed [31:0]  t_next;
    logic [63:0]         tsq_reg;
    logic [63:0]         tsq_next;
    logic [63:0]         rsq_reg;
    logic [63:0]         rsq_next;
    logic [63:0]         s_reg;
    logic [63:0]         s_next;
    logic                miss_reg;
    logic                miss_next;
    logic [63:0]         rad_reg;
    logic [63:0]         rad_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tv_next[i]  = $signed({1'b0, tm_reg}) * $signed(cfg.v[i]);
            mc_next[i]  = sat32(64'($signed(cfg.c[i])) + 64'(tv_reg[i] >>> FRAC_BITS));
            l_next[i]   = sat32(64'($signed(mc_reg[2][i])) - 64'($signed(o_reg[2][i])));
            dp_next[i]  = $signed(d_reg[3][i]) * l_reg[i];
            lsq_next[i] = l_reg[i] * l_reg[i];
        end
        dot_next  = 52'(dp_reg[0]) + 52'(dp_reg[1]) + 52'(dp_reg[2]);
        a_next    = lsq_reg[0] + lsq_reg[1] + lsq_reg[2];
        t_next    = sat32(64'(dot_reg >>> FRAC_BITS));
        tsq_next  = t_reg[6] * t_reg[6];
        rsq_next  = 64'(cfg.radius) * 64'(cfg.radius);
        s_next    = tsq_reg + rsq_reg;
        miss_next = s_reg < a_reg[8];
        rad_next  = s_reg - a_reg[8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[8:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg[0] <= in_o;
            d_reg[0] <= in_d;
            tm_reg   <= in_tm;
            for (int k = 1; k < 10; k++)
            begin
                o_reg[k] <= o_reg[k-1];
                d_reg[k] <= d_reg[k-1];
            end
            tv_reg    <= tv_next;
            mc_reg[2] <= mc_next;
            for (int k = 3; k < 10; k++)
            begin
                mc_reg[k] <= mc_reg[k-1];
            end
            l_reg    <= l_next;
            dp_reg   <= dp_next;
            lsq_reg  <= lsq_next;
            dot_reg  <= dot_next;
            a_reg[5] <= a_next;
            a_reg[6] <= a_reg[5];
            a_reg[7] <= a_reg[6];
            a_reg[8] <= a_reg[7];
            t_reg[6] <= t_next;
            t_reg[7] <= t_reg[6];
            t_reg[8] <= t_reg[7];
            t_reg[9] <= t_reg[8];
            tsq_reg  <= tsq_next;
            rsq_reg  <= rsq_next;
            s_reg    <= s_next;
            miss_reg <= miss_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid    = vld_reg[9];
    assign out_rad      = rad_reg;
    assign out_mid.o    = o_reg[9];
    assign out_mid.d    = d_reg[9];
    assign out_mid.mc   = mc_reg[9];
    assign out_mid.t    = t_reg[9];
    assign out_mid.miss = miss_reg;

endmodule
`default_nettype wire

>>> rtl/core/mrsi_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsi_sqrt
// Pipelined 64-bit integer square root, one result bit per stage, with a
// side band that travels alongside.
// ----------------------------------------------------------------------------
module mrsi_sqrt #(
    parameter int SIDE_W = 8
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               en,
    input  wire               in_valid,
    input  wire [63:0]        in_rad,
    input  wire [SIDE_W-1:0]  in_side,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int STEPS = 32;
    localparam int RW    = 35;

    logic [STEPS-1:0]  vld_reg;
    logic [63:0]       x_reg     [STEPS];
    logic [RW-1:0]     rem_reg   [STEPS];
    logic [31:0]       root_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg  [STEPS];
    logic [63:0]       x_cur     [STEPS];
    logic [RW-1:0]     rem_cur   [STEPS];
    logic [31:0]       root_cur  [STEPS];
    logic [63:0]       x_next    [STEPS];
    logic [RW-1:0]     rem_next  [STEPS];
    logic [31:0]       root_next [STEPS];
    logic [RW-1:0]     acc       [STEPS];
    logic [RW-1:0]     trial     [STEPS];

    always_comb
    begin
        x_cur[0]    = in_rad;
        rem_cur[0]  = '0;
        root_cur[0] = '0;
        for (int g = 1; g < STEPS; g++)
        begin
            x_cur[g]    = x_reg[g-1];
            rem_cur[g]  = rem_reg[g-1];
            root_cur[g] = root_reg[g-1];
        end
        for (int g = 0; g < STEPS; g++)
        begin
            acc[g]       = {rem_cur[g][RW-3:0], x_cur[g][63:62]};
            trial[g]     = RW'({root_cur[g], 2'b01});
            x_next[g]    = {x_cur[g][61:0], 2'b00};
            rem_next[g]  = (acc[g] >= trial[g]) ? acc[g] - trial[g] : acc[g];
            root_next[g] = {root_cur[g][30:0], acc[g] >= trial[g]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int g = 1; g < STEPS; g++)
            begin
                side_reg[g] <= side_reg[g-1];
            end
            for (int g = 0; g < STEPS; g++)
            begin
                x_reg[g]    <= x_next[g];
                rem_reg[g]  <= rem_next[g];
                root_reg[g] <= root_next[g];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

>>> rtl/core/mrsi_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsi_norm
// Three-lane pipelined restoring divider: magnitude times 2^FRAC_BITS over
// the vector length, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mrsi_norm #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       en,
    input  wire                       in_valid,
    input  wire [2:0][30:0]           in_mag,
    input  wire [31:0]                in_m,
    input  wire [SIDE_W-1:0]          in_side,
    output logic                      out_valid,
    output logic [2:0][FRAC_BITS:0]   out_q,
    output logic [31:0]               out_m,
    output logic [SIDE_W-1:0]         out_side
);
    localparam int STEPS = FRAC_BITS + 1;

    logic [STEPS-1:0]  vld_reg;
    logic [31:0]       rem_reg  [STEPS][3];
    logic [FRAC_BITS:0] q_reg   [STEPS][3];
    logic [31:0]       m_reg    [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [32:0]       acc      [STEPS][3];
    logic [FRAC_BITS:0] q_cur   [STEPS][3];
    logic [31:0]       m_cur    [STEPS];
    logic [31:0]       rem_next [STEPS][3];
    logic [FRAC_BITS:0] q_next  [STEPS][3];

    always_comb
    begin
        m_cur[0] = in_m;
        for (int l = 0; l < 3; l++)
        begin
            acc[0][l]   = 33'(in_mag[l]);
            q_cur[0][l] = '0;
        end
        for (int g = 1; g < STEPS; g++)
        begin
            m_cur[g] = m_reg[g-1];
            for (int l = 0; l < 3; l++)
            begin
                acc[g][l]   = {rem_reg[g-1][l], 1'b0};
                q_cur[g][l] = q_reg[g-1][l];
            end
        end
        for (int g = 0; g < STEPS; g++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (acc[g][l] >= {1'b0, m_cur[g]})
                begin
                    rem_next[g][l] = 32'(acc[g][l] - {1'b0, m_cur[g]});
                    q_next[g][l]   = {q_cur[g][l][FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_next[g][l] = acc[g][l][31:0];
                    q_next[g][l]   = {q_cur[g][l][FRAC_BITS-1:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= STEPS'({vld_reg, in_valid});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            m_reg[0]    <= in_m;
            for (int g = 1; g < STEPS; g++)
            begin
                side_reg[g] <= side_reg[g-1];
                m_reg[g]    <= m_reg[g-1];
            end
            for (int g = 0; g < STEPS; g++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[g][l] <= rem_next[g][l];
                    q_reg[g][l]   <= q_next[g][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            out_q[l] = q_reg[STEPS-1][l];
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_m     = m_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

>>> rtl/core/moving_ray_sphere_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// moving_ray_sphere_intersect
// Ray against one linearly moving sphere: hit, distance, point, unit normal.
//
//   channel   direction  fields (low bit up)
//   s_axis    in         origin_x/y/z, dir_x/y/z, ray_time (tdata)
//   m_axis    out        tdata: distance, point_x/y/z, normal_x/y/z,
//                        hit_object; tuser: hit
//   cfg       in         cfg_index selects register, cfg_data holds value
//
// One ray per cycle unless the output stalls; the pipeline is made up mostly
// of two 32-stage square roots and a FRAC_BITS + 1 stage divider.
// Reset clears all valid bits and loads register defaults (radius 1.0).
// The whole pipeline holds while a result waits with m_axis_tready low;
// a new request is taken in the same cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module moving_ray_sphere_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_time, pad
    input  wire [167:0]   s_axis_tdata,
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z,
    // hit_object, pad
    output logic [199:0]  m_axis_tdata,
    // hit
    output logic          m_axis_tuser,
    input  wire           cfg_valid,
    output logic          cfg_ready,
    input  wire [2:0]     cfg_index,
    input  wire [31:0]    cfg_data
);
    import mrsi_pkg::*;

    cfg_t               cfg_reg;
    logic               en;
    logic [2:0][31:0]   in_o;
    logic [2:0][17:0]   in_d;
    logic               fr_valid;
    logic [63:0]        fr_rad;
    ray_mid_t           fr_mid;
    logic               sq1_valid;
    logic [31:0]        sq1_root;
    logic [$bits(ray_mid_t)-1:0] sq1_side;
    ray_mid_t           rt_mid;

    logic [5:0]         vld_reg;
    logic signed [33:0] t1_next;
    logic signed [33:0] t2_next;
    logic signed [33:0] len_next;
    logic               r_hit_reg;
    logic [30:0]        r_dist_reg;
    logic [2:0][31:0]   r_o_reg;
    logic [2:0][17:0]   r_d_reg;
    logic [2:0][31:0]   r_mc_reg;

    logic signed [49:0] pr_next [3];
    logic signed [49:0] pr_reg  [3];
    logic               p1_hit_reg;
    logic [30:0]        p1_dist_reg;
    logic [2:0][31:0]   p1_o_reg;
    logic [2:0][31:0]   p1_mc_reg;

    logic [2:0][31:0]   p_next;
    logic [2:0][31:0]   p2_p_reg;
    logic               p2_hit_reg;
    logic [30:0]        p2_dist_reg;
    logic [2:0][31:0]   p2_mc_reg;

    logic signed [32:0] n0 [3];
    logic signed [32:0] n1 [3];
    logic signed [32:0] n2 [3];
    logic               big1;
    logic               big2;
    logic signed [31:0] nh_next [3];
    logic signed [31:0] nh_reg  [3];
    logic               n1_hit_reg;
    logic [30:0]        n1_dist_reg;
    logic [2:0][31:0]   n1_p_reg;

    logic [63:0]        nsq_next [3];
    logic [63:0]        nsq_reg  [3];
    logic [2:0][30:0]   mag_next;
    logic [2:0]         neg_next;
    surf_t              n2_reg;

    logic [63:0]        n3_rad_reg;
    surf_t              n3_reg;

    logic               sq2_valid;
    logic [31:0]        sq2_root;
    logic [$bits(surf_t)-1:0] sq2_side;
    surf_t              sf;
    hitpt_t             nm_in_side;

    logic                    nm_valid;
    logic [2:0][FRAC_BITS:0] nm_q;
    logic [31:0]             nm_m;
    logic [$bits(hitpt_t)-1:0] nm_side;
    hitpt_t                  hp;

    logic signed [FRAC_BITS+1:0] qs [3];
    logic [2:0][17:0]   nrm_next;
    logic [199:0]       data_next;
    logic               out_vld_reg;
    logic [199:0]       out_data_reg;
    logic               out_user_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.c         <= '0;
            cfg_reg.v         <= '0;
            cfg_reg.radius    <= RADIUS_RESET;
            cfg_reg.object_id <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_CENTER_X:   cfg_reg.c[0]      <= cfg_data;
                REG_CENTER_Y:   cfg_reg.c[1]      <= cfg_data;
                REG_CENTER_Z:   cfg_reg.c[2]      <= cfg_data;
                REG_RADIUS:     cfg_reg.radius    <= cfg_data[30:0];
                REG_VELOCITY_X: cfg_reg.v[0]      <= cfg_data;
                REG_VELOCITY_Y: cfg_reg.v[1]      <= cfg_data;
                REG_VELOCITY_Z: cfg_reg.v[2]      <= cfg_data;
                REG_OBJECT_ID:  cfg_reg.object_id <= cfg_data[15:0];
                default:        cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // global advance
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign in_o[0] = s_axis_tdata[31:0];
    assign in_o[1] = s_axis_tdata[63:32];
    assign in_o[2] = s_axis_tdata[95:64];
    assign in_d[0] = s_axis_tdata[113:96];
    assign in_d[1] = s_axis_tdata[131:114];
    assign in_d[2] = s_axis_tdata[149:132];

    mrsi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_o      (in_o),
        .in_d      (in_d),
        .in_tm     (s_axis_tdata[166:150]),
        .cfg       (cfg_reg),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_mid   (fr_mid)
    );

    mrsi_sqrt #(
        .SIDE_W ($bits(ray_mid_t))
    ) u_sqrt_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_side   (fr_mid),
        .out_valid (sq1_valid),
        .out_root  (sq1_root),
        .out_side  (sq1_side)
    );

    assign rt_mid = ray_mid_t'(sq1_side);

    // root select, hit point, normal vector
    always_comb
    begin
        t1_next  = 34'($signed(rt_mid.t)) - $signed({2'b00, sq1_root});
        t2_next  = 34'($signed(rt_mid.t)) + $signed({2'b00, sq1_root});
        len_next = t1_next[33] ? t2_next : t1_next;
        for (int i = 0; i < 3; i++)
        begin
            pr_next[i] = $signed({1'b0, r_dist_reg}) * $signed(r_d_reg[i]);
            p_next[i]  = sat32(64'($signed(p1_o_reg[i])) + 64'(pr_reg[i] >>> FRAC_BITS));
            n0[i]      = 33'($signed(p2_p_reg[i])) - 33'($signed(p2_mc_reg[i]));
        end
        big1 = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (n0[i] > 33'sd2147483647 || n0[i] < -33'sd2147483647)
            begin
                big1 = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            n1[i] = big1 ? (n0[i] >>> 1) : n0[i];
        end
        big2 = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (n1[i] > 33'sd2147483647 || n1[i] < -33'sd2147483647)
            begin
                big2 = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            n2[i]       = big2 ? (n1[i] >>> 1) : n1[i];
            nh_next[i]  = n2[i][31:0];
            nsq_next[i] = nh_reg[i] * nh_reg[i];
            mag_next[i] = nh_reg[i][31] ? 31'(-nh_reg[i]) : nh_reg[i][30:0];
            neg_next[i] = nh_reg[i][31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], sq1_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_hit_reg  <= !(rt_mid.miss || t2_next[33]);
            r_dist_reg <= (len_next > 34'sd2147483647) ? 31'h7FFFFFFF : len_next[30:0];
            r_o_reg    <= rt_mid.o;
            r_d_reg    <= rt_mid.d;
            r_mc_reg   <= rt_mid.mc;

            pr_reg      <= pr_next;
            p1_hit_reg  <= r_hit_reg;
            p1_dist_reg <= r_dist_reg;
            p1_o_reg    <= r_o_reg;
            p1_mc_reg   <= r_mc_reg;

            p2_p_reg    <= p_next;
            p2_hit_reg  <= p1_hit_reg;
            p2_dist_reg <= p1_dist_reg;
            p2_mc_reg   <= p1_mc_reg;

            nh_reg      <= nh_next;
            n1_hit_reg  <= p2_hit_reg;
            n1_dist_reg <= p2_dist_reg;
            n1_p_reg    <= p2_p_reg;

            nsq_reg         <= nsq_next;
            n2_reg.hit      <= n1_hit_reg;
            n2_reg.distance <= n1_dist_reg;
            n2_reg.p        <= n1_p_reg;
            n2_reg.mag      <= mag_next;
            n2_reg.neg      <= neg_next;

            n3_rad_reg  <= nsq_reg[0] + nsq_reg[1] + nsq_reg[2];
            n3_reg      <= n2_reg;
        end
    end

    mrsi_sqrt #(
        .SIDE_W ($bits(surf_t))
    ) u_sqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[5]),
        .in_rad    (n3_rad_reg),
        .in_side   (n3_reg),
        .out_valid (sq2_valid),
        .out_root  (sq2_root),
        .out_side  (sq2_side)
    );

    assign sf                  = surf_t'(sq2_side);
    assign nm_in_side.hit      = sf.hit;
    assign nm_in_side.distance = sf.distance;
    assign nm_in_side.p        = sf.p;
    assign nm_in_side.neg      = sf.neg;

    mrsi_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(hitpt_t))
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq2_valid),
        .in_mag    (sf.mag),
        .in_m      (sq2_root),
        .in_side   (nm_in_side),
        .out_valid (nm_valid),
        .out_q     (nm_q),
        .out_m     (nm_m),
        .out_side  (nm_side)
    );

    assign hp = hitpt_t'(nm_side);

    // result assembly
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i]       = $signed({1'b0, nm_q[i]});
            nrm_next[i] = '0;
            if (nm_m != '0)
            begin
                nrm_next[i] = hp.neg[i] ? 18'(-qs[i]) : 18'(qs[i]);
            end
        end
        data_next = '0;
        if (hp.hit)
        begin
            data_next = {3'b000, cfg_reg.object_id, nrm_next[2], nrm_next[1], nrm_next[0],
                         hp.p[2], hp.p[1], hp.p[0], hp.distance};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= nm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= data_next;
            out_user_reg <= hp.hit;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
`default_nettype wire

>>> rtl/core/mrsi_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsi_check
// Port-level checks for the moving ray-sphere intersect block.
// ----------------------------------------------------------------------------
module mrsi_check (
    input wire           clk,
    input wire           rst_n,
    input wire           s_axis_tvalid,
    input wire           s_axis_tready,
    input wire [167:0]   s_axis_tdata,
    input wire           m_axis_tvalid,
    input wire           m_axis_tready,
    input wire [199:0]   m_axis_tdata,
    input wire           m_axis_tuser,
    input wire           cfg_valid,
    input wire           cfg_ready,
    input wire [2:0]     cfg_index,
    input wire [31:0]    cfg_data
);

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss result carries nonzero data");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind moving_ray_sphere_intersect mrsi_check u_mrsi_check (.*);
`default_nettype wire
